### design/mcpw_pkg.sv
// Shared constants for the multi-channel progress watchdog.
package mcpw_pkg;

   localparam int TIME_BITS_DEFAULT  = 32;
   localparam int COUNT_BITS_DEFAULT = 64;

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CAUSE_BITS     = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_CYCLE_TIMEOUT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TASK_TIMEOUT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GVT_TIMEOUT   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FF_TIMEOUT    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CYCLE_WARN    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TASK_WARN     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GVT_WARN      = 3'd6;

   localparam logic [CSR_DATA_BITS-1:0] CYCLE_TIMEOUT_RESET = 32'd600;
   localparam logic [CSR_DATA_BITS-1:0] TASK_TIMEOUT_RESET  = 32'd600;
   localparam logic [CSR_DATA_BITS-1:0] GVT_TIMEOUT_RESET   = 32'd600;
   localparam logic [CSR_DATA_BITS-1:0] FF_TIMEOUT_RESET    = 32'd3600;
   localparam logic [CSR_DATA_BITS-1:0] CYCLE_WARN_RESET    = 32'd10;
   localparam logic [CSR_DATA_BITS-1:0] TASK_WARN_RESET     = 32'd20;
   localparam logic [CSR_DATA_BITS-1:0] GVT_WARN_RESET      = 32'd100;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   localparam logic [CAUSE_BITS-1:0] CAUSE_NONE  = 3'd0;
   localparam logic [CAUSE_BITS-1:0] CAUSE_FF    = 3'd1;
   localparam logic [CAUSE_BITS-1:0] CAUSE_CYCLE = 3'd2;
   localparam logic [CAUSE_BITS-1:0] CAUSE_TASK  = 3'd3;
   localparam logic [CAUSE_BITS-1:0] CAUSE_GVT   = 3'd4;

endpackage

### design/multi_channel_progress_watchdog.sv
// Progress watchdog top level: input register, check logic, result register.
//
//   channel | direction | handshake           | word
//   req     | in        | req_valid/req_ready | start or tick sample
//   rsp     | out       | rsp_valid/rsp_ready | warnings and timeout cause
//   csr     | in        | csr_write_enable    | threshold register write
//
// One word per cycle while rsp is ready; each word goes through both registers to rsp.
// The checks run in one pass between the input register and the result register.
// Reset (synchronous) clears the progress state and loads the register defaults.
// A stalled rsp holds its word; req keeps accepting while the input register can drain.
module multi_channel_progress_watchdog #(
   parameter int TIME_BITS  = mcpw_pkg::TIME_BITS_DEFAULT,
   parameter int COUNT_BITS = mcpw_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [TIME_BITS-1:0]                req_now_secs,
   input  logic [COUNT_BITS-1:0]               req_cycle_count,
   input  logic [COUNT_BITS-1:0]               req_commit_cycles,
   input  logic [COUNT_BITS-1:0]               req_abort_cycles,
   input  logic [COUNT_BITS-1:0]               req_virtual_time,
   input  logic                                req_at_prompt,
   input  logic                                req_fast_forward,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_cycle_stall_warn,
   output logic                                rsp_task_stall_warn,
   output logic                                rsp_gvt_stall_warn,
   output logic [mcpw_pkg::CAUSE_BITS-1:0]     rsp_timeout_cause,
   input  logic                                csr_write_enable,
   input  logic [mcpw_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mcpw_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int CMP_BITS = (TIME_BITS > mcpw_pkg::CSR_DATA_BITS) ?
                             TIME_BITS : mcpw_pkg::CSR_DATA_BITS;

   function automatic logic reached(input logic [TIME_BITS-1:0] now,
                                    input logic [TIME_BITS-1:0] then,
                                    input logic [mcpw_pkg::CSR_DATA_BITS-1:0] thr);
      logic [TIME_BITS-1:0] diff;
      diff = now - then;
      return CMP_BITS'(diff) >= CMP_BITS'(thr);
   endfunction

   // configuration registers
   logic [mcpw_pkg::CSR_DATA_BITS-1:0] cyc_to_ff, task_to_ff, gvt_to_ff, ff_to_ff;
   logic [mcpw_pkg::CSR_DATA_BITS-1:0] cyc_warn_ff, task_warn_ff, gvt_warn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cyc_to_ff    <= mcpw_pkg::CYCLE_TIMEOUT_RESET;
         task_to_ff   <= mcpw_pkg::TASK_TIMEOUT_RESET;
         gvt_to_ff    <= mcpw_pkg::GVT_TIMEOUT_RESET;
         ff_to_ff     <= mcpw_pkg::FF_TIMEOUT_RESET;
         cyc_warn_ff  <= mcpw_pkg::CYCLE_WARN_RESET;
         task_warn_ff <= mcpw_pkg::TASK_WARN_RESET;
         gvt_warn_ff  <= mcpw_pkg::GVT_WARN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            mcpw_pkg::REG_CYCLE_TIMEOUT: cyc_to_ff    <= csr_write_data;
            mcpw_pkg::REG_TASK_TIMEOUT:  task_to_ff   <= csr_write_data;
            mcpw_pkg::REG_GVT_TIMEOUT:   gvt_to_ff    <= csr_write_data;
            mcpw_pkg::REG_FF_TIMEOUT:    ff_to_ff     <= csr_write_data;
            mcpw_pkg::REG_CYCLE_WARN:    cyc_warn_ff  <= csr_write_data;
            mcpw_pkg::REG_TASK_WARN:     task_warn_ff <= csr_write_data;
            mcpw_pkg::REG_GVT_WARN:      gvt_warn_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register
   logic                  in_valid_ff;
   logic                  in_type_ff, in_prompt_ff, in_ffwd_ff;
   logic [TIME_BITS-1:0]  in_now_ff;
   logic [COUNT_BITS-1:0] in_cyc_ff, in_tasks_ff, in_vt_ff;
   logic                  rsp_valid_ff;
   logic                  advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_type_ff   <= req_type;
         in_now_ff    <= req_now_secs;
         in_cyc_ff    <= req_cycle_count;
         in_tasks_ff  <= req_commit_cycles + req_abort_cycles;
         in_vt_ff     <= req_virtual_time;
         in_prompt_ff <= req_at_prompt;
         in_ffwd_ff   <= req_fast_forward;
      end
   end

   // progress state
   logic [TIME_BITS-1:0]            non_ff_ff, cyc_time_ff, task_time_ff, gvt_time_ff;
   logic [TIME_BITS-1:0]            non_ff_in, cyc_time_in, task_time_in, gvt_time_in;
   logic [COUNT_BITS-1:0]           prev_cyc_ff, prev_task_ff, prev_vt_ff;
   logic [COUNT_BITS-1:0]           prev_cyc_in, prev_task_in, prev_vt_in;
   logic [mcpw_pkg::CAUSE_BITS-1:0] cause_ff, cause_in;
   logic                            w_cyc_in, w_task_in, w_gvt_in;

   logic [TIME_BITS-1:0] m_non, m_cyc, m_task, m_gvt;
   logic [TIME_BITS-1:0] u_non, u_cyc, u_task, u_gvt;
   logic                 in_run, fire_ff, fire_cyc, fire_task, fire_gvt;

   always_comb begin
      in_run = (in_vt_ff != {COUNT_BITS{1'b1}}) && (in_vt_ff != '0);

      // mode rules
      m_non  = non_ff_ff;
      m_cyc  = cyc_time_ff;
      m_task = task_time_ff;
      m_gvt  = gvt_time_ff;
      if (in_prompt_ff) begin
         m_non  = in_now_ff;
         m_cyc  = in_now_ff;
         m_task = in_now_ff;
         m_gvt  = in_now_ff;
      end else if (in_ffwd_ff) begin
         m_cyc  = in_now_ff;
         m_task = in_now_ff;
         m_gvt  = in_now_ff;
      end else if (!in_run) begin
         m_task = in_now_ff;
         m_gvt  = in_now_ff;
      end

      // channel checks
      u_non   = in_ffwd_ff ? m_non : in_now_ff;
      fire_ff = in_ffwd_ff && reached(in_now_ff, m_non, ff_to_ff);

      u_cyc    = (in_cyc_ff > prev_cyc_ff) ? in_now_ff : m_cyc;
      fire_cyc = reached(in_now_ff, u_cyc, cyc_to_ff);

      u_task    = (in_tasks_ff > prev_task_ff) ? in_now_ff : m_task;
      fire_task = reached(in_now_ff, u_task, task_to_ff);

      u_gvt    = (in_vt_ff > prev_vt_ff) ? in_now_ff : m_gvt;
      fire_gvt = reached(in_now_ff, u_gvt, gvt_to_ff);

      non_ff_in    = non_ff_ff;
      cyc_time_in  = cyc_time_ff;
      task_time_in = task_time_ff;
      gvt_time_in  = gvt_time_ff;
      prev_cyc_in  = prev_cyc_ff;
      prev_task_in = prev_task_ff;
      prev_vt_in   = prev_vt_ff;
      cause_in     = cause_ff;
      w_cyc_in     = 1'b0;
      w_task_in    = 1'b0;
      w_gvt_in     = 1'b0;

      if (in_type_ff == mcpw_pkg::REQ_START) begin
         non_ff_in    = in_now_ff;
         cyc_time_in  = in_now_ff;
         task_time_in = in_now_ff;
         gvt_time_in  = in_now_ff;
         prev_cyc_in  = '0;
         prev_task_in = '0;
         prev_vt_in   = '0;
         cause_in     = mcpw_pkg::CAUSE_NONE;
      end else if (cause_ff == mcpw_pkg::CAUSE_NONE) begin
         non_ff_in    = u_non;
         cyc_time_in  = m_cyc;
         task_time_in = m_task;
         gvt_time_in  = m_gvt;
         if (fire_ff) begin
            cause_in = mcpw_pkg::CAUSE_FF;
         end else begin
            cyc_time_in = u_cyc;
            w_cyc_in    = reached(in_now_ff, u_cyc, cyc_warn_ff);
            if (fire_cyc) begin
               cause_in = mcpw_pkg::CAUSE_CYCLE;
            end else begin
               task_time_in = u_task;
               w_task_in    = reached(in_now_ff, u_task, task_warn_ff);
               if (fire_task) begin
                  cause_in = mcpw_pkg::CAUSE_TASK;
               end else begin
                  gvt_time_in = u_gvt;
                  w_gvt_in    = reached(in_now_ff, u_gvt, gvt_warn_ff);
                  if (fire_gvt) begin
                     cause_in = mcpw_pkg::CAUSE_GVT;
                  end else begin
                     prev_cyc_in  = in_cyc_ff;
                     prev_task_in = in_tasks_ff;
                     prev_vt_in   = in_vt_ff;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         non_ff_ff    <= '0;
         cyc_time_ff  <= '0;
         task_time_ff <= '0;
         gvt_time_ff  <= '0;
         prev_cyc_ff  <= '0;
         prev_task_ff <= '0;
         prev_vt_ff   <= '0;
         cause_ff     <= mcpw_pkg::CAUSE_NONE;
      end else if (advance) begin
         non_ff_ff    <= non_ff_in;
         cyc_time_ff  <= cyc_time_in;
         task_time_ff <= task_time_in;
         gvt_time_ff  <= gvt_time_in;
         prev_cyc_ff  <= prev_cyc_in;
         prev_task_ff <= prev_task_in;
         prev_vt_ff   <= prev_vt_in;
         cause_ff     <= cause_in;
      end
   end

   // result register
   logic                            rsp_w_cyc_ff, rsp_w_task_ff, rsp_w_gvt_ff;
   logic [mcpw_pkg::CAUSE_BITS-1:0] rsp_cause_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_w_cyc_ff  <= w_cyc_in;
         rsp_w_task_ff <= w_task_in;
         rsp_w_gvt_ff  <= w_gvt_in;
         rsp_cause_ff  <= cause_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cycle_stall_warn = rsp_w_cyc_ff;
   assign rsp_task_stall_warn  = rsp_w_task_ff;
   assign rsp_gvt_stall_warn   = rsp_w_gvt_ff;
   assign rsp_timeout_cause    = rsp_cause_ff;

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      advance && (in_type_ff == mcpw_pkg::REQ_START) |=>
         rsp_valid_ff && (rsp_cause_ff == mcpw_pkg::CAUSE_NONE) &&
         !rsp_w_cyc_ff && !rsp_w_task_ff && !rsp_w_gvt_ff)
      else $error("start word did not clear the result");

   a_cause_latched: assert property (@(posedge clock) disable iff (reset)
      (cause_ff != mcpw_pkg::CAUSE_NONE) &&
         !(advance && (in_type_ff == mcpw_pkg::REQ_START)) |=> $stable(cause_ff))
      else $error("latched timeout cause changed without a start word");

   a_rsp_matches_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_cause_ff == cause_ff))
      else $error("result cause differs from latched cause");

   a_unchecked_warn_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((rsp_cause_ff == mcpw_pkg::CAUSE_FF) ||
         (rsp_cause_ff == mcpw_pkg::CAUSE_CYCLE) ||
         (rsp_cause_ff == mcpw_pkg::CAUSE_TASK)) |-> !rsp_w_gvt_ff)
      else $error("virtual time warning raised for an unchecked channel");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !advance)
      else $error("result register overwritten while stalled");

endmodule

### tb/sv/tb_multi_channel_progress_watchdog.sv
// Self-checking testbench for the multi-channel progress watchdog.
module tb_multi_channel_progress_watchdog;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TB_TIME_BITS  = mcpw_pkg::TIME_BITS_DEFAULT;
   localparam int TB_COUNT_BITS = mcpw_pkg::COUNT_BITS_DEFAULT;
   localparam int PHASE_WORDS   = 120;
   localparam int RAND_PHASES   = 9;
   localparam int IDLE_LIMIT    = 2000;

   typedef struct {
      logic                     kind;
      logic [TB_TIME_BITS-1:0]  now;
      logic [TB_COUNT_BITS-1:0] cycles;
      logic [TB_COUNT_BITS-1:0] commits;
      logic [TB_COUNT_BITS-1:0] aborts;
      logic [TB_COUNT_BITS-1:0] vtime;
      logic                     prompt;
      logic                     ffwd;
   } sample_type;

   typedef struct packed {
      logic                            cyc_warn;
      logic                            work_warn;
      logic                            gvt_warn;
      logic [mcpw_pkg::CAUSE_BITS-1:0] cause;
   } verdict_type;

   logic clock;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_type = mcpw_pkg::REQ_START;
   logic [TB_TIME_BITS-1:0]             req_now_secs = '0;
   logic [TB_COUNT_BITS-1:0]            req_cycle_count = '0;
   logic [TB_COUNT_BITS-1:0]            req_commit_cycles = '0;
   logic [TB_COUNT_BITS-1:0]            req_abort_cycles = '0;
   logic [TB_COUNT_BITS-1:0]            req_virtual_time = '0;
   logic                                req_at_prompt = 1'b0;
   logic                                req_fast_forward = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_cycle_stall_warn;
   logic                                rsp_task_stall_warn;
   logic                                rsp_gvt_stall_warn;
   logic [mcpw_pkg::CAUSE_BITS-1:0]     rsp_timeout_cause;
   logic                                csr_write_enable = 1'b0;
   logic [mcpw_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [mcpw_pkg::CSR_DATA_BITS-1:0]  csr_write_data = '0;

   // predictor state
   logic [mcpw_pkg::CSR_DATA_BITS-1:0] limits [7];
   logic [mcpw_pkg::CSR_DATA_BITS-1:0] reset_vals [7];
   logic [TB_TIME_BITS-1:0]            ff_mark, cyc_mark, work_mark, gvt_mark;
   logic [TB_COUNT_BITS-1:0]           last_cycles, last_work, last_vtime;
   logic [mcpw_pkg::CAUSE_BITS-1:0]    held_cause;

   sample_type  pending [$];
   verdict_type verdicts [$];
   sample_type  cur;

   int  send_gap = 0;
   int  recv_gap = 0;
   bit  quiet = 1'b0;
   int  words_sent = 0;
   int  results_seen = 0;
   int  error_count = 0;
   int  phases_run = 0;
   int  idle_cycles = 0;
   int  timeouts [1:4] = '{0, 0, 0, 0};

   multi_channel_progress_watchdog dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_type             (req_type),
      .req_now_secs         (req_now_secs),
      .req_cycle_count      (req_cycle_count),
      .req_commit_cycles    (req_commit_cycles),
      .req_abort_cycles     (req_abort_cycles),
      .req_virtual_time     (req_virtual_time),
      .req_at_prompt        (req_at_prompt),
      .req_fast_forward     (req_fast_forward),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_cycle_stall_warn (rsp_cycle_stall_warn),
      .rsp_task_stall_warn  (rsp_task_stall_warn),
      .rsp_gvt_stall_warn   (rsp_gvt_stall_warn),
      .rsp_timeout_cause    (rsp_timeout_cause),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic verdict_type judge_sample(sample_type s);
      verdict_type              v;
      logic [TB_COUNT_BITS-1:0] work;
      logic [TB_TIME_BITS-1:0]  gap;
      logic                     running;
      logic                     stop;
      v = '0;
      work = s.commits + s.aborts;
      stop = 1'b0;
      if (s.kind == mcpw_pkg::REQ_START) begin
         ff_mark = s.now;
         cyc_mark = s.now;
         work_mark = s.now;
         gvt_mark = s.now;
         last_cycles = '0;
         last_work = '0;
         last_vtime = '0;
         held_cause = mcpw_pkg::CAUSE_NONE;
      end else if (held_cause == mcpw_pkg::CAUSE_NONE) begin
         running = (s.vtime != '1) && (s.vtime != '0);
         if (s.prompt) begin
            ff_mark = s.now;
            cyc_mark = s.now;
            work_mark = s.now;
            gvt_mark = s.now;
         end else if (s.ffwd) begin
            cyc_mark = s.now;
            work_mark = s.now;
            gvt_mark = s.now;
         end else if (!running) begin
            work_mark = s.now;
            gvt_mark = s.now;
         end
         if (!s.ffwd) begin
            ff_mark = s.now;
         end else begin
            gap = s.now - ff_mark;
            if (gap >= limits[mcpw_pkg::REG_FF_TIMEOUT]) begin
               held_cause = mcpw_pkg::CAUSE_FF;
               stop = 1'b1;
            end
         end
         if (!stop) begin
            if (s.cycles > last_cycles) cyc_mark = s.now;
            gap = s.now - cyc_mark;
            v.cyc_warn = gap >= limits[mcpw_pkg::REG_CYCLE_WARN];
            if (gap >= limits[mcpw_pkg::REG_CYCLE_TIMEOUT]) begin
               held_cause = mcpw_pkg::CAUSE_CYCLE;
               stop = 1'b1;
            end
         end
         if (!stop) begin
            if (work > last_work) work_mark = s.now;
            gap = s.now - work_mark;
            v.work_warn = gap >= limits[mcpw_pkg::REG_TASK_WARN];
            if (gap >= limits[mcpw_pkg::REG_TASK_TIMEOUT]) begin
               held_cause = mcpw_pkg::CAUSE_TASK;
               stop = 1'b1;
            end
         end
         if (!stop) begin
            if (s.vtime > last_vtime) gvt_mark = s.now;
            gap = s.now - gvt_mark;
            v.gvt_warn = gap >= limits[mcpw_pkg::REG_GVT_WARN];
            if (gap >= limits[mcpw_pkg::REG_GVT_TIMEOUT]) begin
               held_cause = mcpw_pkg::CAUSE_GVT;
               stop = 1'b1;
            end
         end
         if (stop) begin
            timeouts[held_cause]++;
         end else begin
            last_cycles = s.cycles;
            last_work = work;
            last_vtime = s.vtime;
         end
      end
      v.cause = held_cause;
      return v;
   endfunction

   task automatic note_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [2:0] got, input logic [2:0] want);
      if (got !== want)
         note_error($sformatf("result %0d %s got %0d expected %0d",
                              results_seen, name, got, want));
   endtask

   task automatic push_word(input logic kind, input logic [31:0] now, input logic [63:0] cyc,
                            input logic [63:0] com, input logic [63:0] abt,
                            input logic [63:0] vt, input logic prompt, input logic ffwd);
      sample_type s;
      s.kind = kind;
      s.now = now;
      s.cycles = cyc;
      s.commits = com;
      s.aborts = abt;
      s.vtime = vt;
      s.prompt = prompt;
      s.ffwd = ffwd;
      pending.push_back(s);
   endtask

   // one start followed by a run of ticks with mostly monotonic progress, with occasional random junk words mixed in
   task automatic queue_episode();
      sample_type               s;
      sample_type               junk;
      logic [TB_COUNT_BITS-1:0] vbase;
      logic                     ffwd;
      int                       r;
      s.kind = mcpw_pkg::REQ_START;
      s.now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200) : $urandom;
      s.cycles = rand64();
      s.commits = rand64();
      s.aborts = rand64();
      s.vtime = rand64();
      s.prompt = 1'($urandom_range(0, 1));
      s.ffwd = 1'($urandom_range(0, 1));
      vbase = rand64();
      ffwd = 1'b0;
      pending.push_back(s);
      repeat ($urandom_range(2, 30)) begin
         if ($urandom_range(0, 11) == 0) begin
            junk.kind = ($urandom_range(0, 3) == 0) ? mcpw_pkg::REQ_START : mcpw_pkg::REQ_TICK;
            junk.now = $urandom;
            junk.cycles = rand64();
            junk.commits = rand64();
            junk.aborts = rand64();
            junk.vtime = rand64();
            junk.prompt = 1'($urandom_range(0, 1));
            junk.ffwd = 1'($urandom_range(0, 1));
            pending.push_back(junk);
         end
         s.kind = mcpw_pkg::REQ_TICK;
         r = $urandom_range(0, 19);
         if (r < 17) s.now += $urandom_range(0, 30);
         else if (r < 19) s.now += $urandom_range(0, 700);
         else s.now += $urandom;
         r = $urandom_range(0, 9);
         if (r < 7) s.cycles += $urandom_range(1, 5000);
         else if (r == 7) s.cycles -= $urandom_range(1, 5000);
         if ($urandom_range(0, 9) < 6) s.commits += $urandom_range(1, 3000);
         if ($urandom_range(0, 9) < 3) s.aborts += $urandom_range(1, 3000);
         r = $urandom_range(0, 19);
         if (r < 2) begin
            s.vtime = '0;
         end else if (r < 4) begin
            s.vtime = '1;
         end else begin
            if (r == 4) vbase -= $urandom_range(1, 1000);
            else if (r < 15) vbase += $urandom_range(1, 1000);
            s.vtime = vbase;
         end
         s.prompt = ($urandom_range(0, 19) == 0);
         if ($urandom_range(0, 9) == 0) ffwd = ~ffwd;
         s.ffwd = ffwd;
         pending.push_back(s);
      end
   endtask

   task automatic write_reg(input int idx, input logic [mcpw_pkg::CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx[mcpw_pkg::CSR_INDEX_BITS-1:0];
      csr_write_data <= val;
      limits[idx] = val;
   endtask

   task automatic drain();
      while (pending.size() != 0 || req_valid || verdicts.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // driver: advance the pending queue, predict each accepted word
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            verdicts.push_back(judge_sample(cur));
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 14);
               req_valid <= 1'b0;
            end else if (pending.size() != 0) begin
               cur = pending.pop_front();
               req_valid <= 1'b1;
               req_type <= cur.kind;
               req_now_secs <= cur.now;
               req_cycle_count <= cur.cycles;
               req_commit_cycles <= cur.commits;
               req_abort_cycles <= cur.aborts;
               req_virtual_time <= cur.vtime;
               req_at_prompt <= cur.prompt;
               req_fast_forward <= cur.ffwd;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdicts.size() == 0) begin
               note_error($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
               want = verdicts.pop_front();
               check_field("cycle_stall_warn", 3'(rsp_cycle_stall_warn), 3'(want.cyc_warn));
               check_field("task_stall_warn", 3'(rsp_task_stall_warn), 3'(want.work_warn));
               check_field("gvt_stall_warn", 3'(rsp_gvt_stall_warn), 3'(want.gvt_warn));
               check_field("timeout_cause", rsp_timeout_cause, want.cause);
            end
            results_seen++;
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 14);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [mcpw_pkg::CSR_DATA_BITS-1:0] val;
      reset_vals = '{mcpw_pkg::CYCLE_TIMEOUT_RESET, mcpw_pkg::TASK_TIMEOUT_RESET,
                     mcpw_pkg::GVT_TIMEOUT_RESET, mcpw_pkg::FF_TIMEOUT_RESET,
                     mcpw_pkg::CYCLE_WARN_RESET, mcpw_pkg::TASK_WARN_RESET,
                     mcpw_pkg::GVT_WARN_RESET};
      limits = reset_vals;
      ff_mark = '0;
      cyc_mark = '0;
      work_mark = '0;
      gvt_mark = '0;
      last_cycles = '0;
      last_work = '0;
      last_vtime = '0;
      held_cause = mcpw_pkg::CAUSE_NONE;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words under reset thresholds
      push_word(mcpw_pkg::REQ_TICK, 0, 0, 0, 0, 0, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_START, 1000, '1, '1, '1, '1, 1'b1, 1'b1);
      push_word(mcpw_pkg::REQ_TICK, 1005, 100, 5, 5, 50, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_TICK, 1016, 100, 5, 5, 60, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_TICK, 1040, 200, '1, 2, '1, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_TICK, 1100, 200, '1, 2, 0, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_TICK, 5000, 200, '1, 2, 0, 1'b1, 1'b1);
      push_word(mcpw_pkg::REQ_TICK, 7000, 200, '1, 2, 0, 1'b0, 1'b1);
      push_word(mcpw_pkg::REQ_TICK, 8600, 200, '1, 2, 0, 1'b0, 1'b1);
      push_word(mcpw_pkg::REQ_TICK, 8601, 300, '1, 3, 70, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_START, 32'hFFFF_FFF0, 0, 0, 0, 0, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_TICK, 32'h5, '1, '1, '1, 1, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_TICK, 32'h300, '1, '1, '1, 1, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_START, 0, 0, 0, 0, 0, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_TICK, 10, 1, 0, 0, 5, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_TICK, 700, 2, 0, 0, 6, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_START, 0, 0, 0, 0, 0, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_TICK, 5, 1, 1, 0, 1, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_TICK, 650, 2, 1, 1, 1, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_TICK, 32'hFFFF_FFFF, '1, '1, '1, '1, 1'b1, 1'b1);
      push_word(mcpw_pkg::REQ_START, 32'hFFFF_FFFF, '1, '1, '1, '1, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_TICK, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000,
                64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                64'h8000_0000_0000_0000, 1'b0, 1'b0);
      push_word(mcpw_pkg::REQ_TICK, 32'h9, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000,
                64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
      drain();
      phases_run++;

      for (int p = 1; p <= RAND_PHASES; p++) begin
         quiet = (p == RAND_PHASES) || ($urandom_range(0, 4) == 0);
         for (int i = 0; i < 7; i++) begin
            if (p == 1) begin
               val = '0;
            end else if (p == 2) begin
               val = '1;
            end else if (p == RAND_PHASES) begin
               val = reset_vals[i];
            end else begin
               case ($urandom_range(0, 9))
                  0: val = '0;
                  1: val = '1;
                  default: val = (i < 4) ? $urandom_range(5, 400) : $urandom_range(0, 120);
               endcase
            end
            write_reg(i, val);
         end
         @(posedge clock);
         csr_write_enable <= 1'b0;
         @(negedge clock);
         while (pending.size() < PHASE_WORDS) queue_episode();
         drain();
         phases_run++;
      end

      $display("Covered %0d words under %0d threshold settings, %0d results checked",
               words_sent, phases_run, results_seen);
      $display("Timeouts predicted: fast-forward %0d, cycle %0d, task %0d, virtual time %0d",
               timeouts[1], timeouts[2], timeouts[3], timeouts[4]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
